@@ hdl/lab_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and codes of the lifetime alias block allocator
package lab_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int PASS_BITS_DEF  = 8;

    localparam int DIM_W     = 14;
    localparam int BPP_W     = 5;
    localparam int POS_W     = 8;
    localparam int RCNT_W    = 9;
    localparam int BIDX_W    = 6;
    localparam int WH_W      = 2 * DIM_W;
    localparam int PROD_W    = WH_W + BPP_W;
    localparam int SIZE_W    = 34;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  created_at;
        logic [POS_W-1:0]  last_used_at;
        logic [DIM_W-1:0]  res_width;
        logic [DIM_W-1:0]  res_height;
        logic [BPP_W-1:0]  bytes_per_pixel;
        logic              transient;
        logic [RCNT_W-1:0] resource_count;
    } lab_req_t;

    typedef struct packed {
        logic [BIDX_W-1:0] block_index;
        logic              reused;
        logic              alias_recorded;
        logic              table_full;
    } lab_rsp_t;

endpackage

@@ hdl/lab_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests, results and configuration
interface lab_req_if;
    import lab_pkg::*;
    logic     valid;
    logic     ready;
    lab_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lab_rsp_if;
    import lab_pkg::*;
    logic     valid;
    logic     ready;
    lab_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lab_cfg_if;
    import lab_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/lifetime_alias_block_allocator.sv @@
`timescale 1ns / 1ps
// top level: best-fit block allocator for aliasing transient resource memory
//
// One request transaction carries one resource lifetime (or a clear command) and
// produces exactly one result transaction. The size is width * height * bytes per
// pixel, computed in two registered multiply steps. A non-transient resource opens a
// new block pinned up to pass resource_count - 1. A transient resource triggers a scan
// of the block table, held in one synchronous ram, reading one entry per cycle and
// keeping the smallest fitting block that is free before the creation pass (lowest
// index on ties). A transient allocation reads each of the N open blocks in turn.
// The result sits in an output register, so the next request is taken while the
// previous result still waits for the sink. The table needs no clearing after reset:
// only entries below the block count are ever read.
module lifetime_alias_block_allocator #(
    parameter int MAX_BLOCKS = lab_pkg::MAX_BLOCKS_DEF,
    parameter int PASS_BITS  = lab_pkg::PASS_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lab_cfg_if.sink   cfg,
    lab_req_if.sink   req,
    lab_rsp_if.source rsp
);
    import lab_pkg::*;

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W = SIZE_W + PASS_BITS;
    localparam int PIN_W   = (PASS_BITS > RCNT_W) ? PASS_BITS : RCNT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL1   = 6'b000010,
        S_MUL2   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [DIM_W-1:0] frame_w_reg, frame_w_next;
    logic [DIM_W-1:0] frame_h_reg, frame_h_next;

    // item datapath
    logic                 transient_reg, transient_next;
    logic [PASS_BITS-1:0] created_reg, created_next;
    logic [PASS_BITS-1:0] last_use_reg, last_use_next;
    logic [PASS_BITS-1:0] pin_reg, pin_next;
    logic [DIM_W-1:0]     w_reg, w_next;
    logic [DIM_W-1:0]     h_reg, h_next;
    logic [BPP_W-1:0]     bpp_reg, bpp_next;
    logic [WH_W-1:0]      wh_reg, wh_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]    best_bytes_reg, best_bytes_next;
    lab_rsp_t             res_reg, res_next;
    lab_rsp_t             rsp_data_reg, rsp_data_next;

    // block table ram: {bytes, free_after}
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [SIZE_W-1:0]    ent_bytes;
    logic [PASS_BITS-1:0] ent_free;
    logic                 ent_fits;
    logic [RCNT_W-1:0]    pin_raw;
    logic [PIN_W-1:0]     pin_ext;
    logic                 req_xfer;
    logic                 rsp_xfer;
    logic                 table_is_full;

    lab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign req_xfer = req.valid && req.ready;
    assign rsp_xfer = rsp_valid_reg && rsp.ready;

    assign ent_bytes     = mem_rdata[ENTRY_W-1:PASS_BITS];
    assign ent_free      = mem_rdata[PASS_BITS-1:0];
    // entry fits when large enough and released strictly before creation
    assign ent_fits      = (ent_bytes >= size_reg) && (ent_free < created_reg);
    assign table_is_full = (count_reg == CNT_W'(MAX_BLOCKS));

    // pin position: count - 1 in 9 bits, saturated to the largest pass value
    assign pin_raw = req.data.resource_count - RCNT_W'(1);
    assign pin_ext = (PIN_W'(pin_raw) > PIN_W'({PASS_BITS{1'b1}}))
                   ? PIN_W'({PASS_BITS{1'b1}}) : PIN_W'(pin_raw);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        pend_next       = 1'b0;
        found_next      = found_reg;
        rsp_valid_next  = rsp_xfer ? 1'b0 : rsp_valid_reg;
        frame_w_next    = frame_w_reg;
        frame_h_next    = frame_h_reg;
        transient_next  = transient_reg;
        created_next    = created_reg;
        last_use_next   = last_use_reg;
        pin_next        = pin_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        bpp_next        = bpp_reg;
        wh_next         = wh_reg;
        size_next       = size_reg;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_bytes_next = best_bytes_reg;
        res_next        = res_reg;
        rsp_data_next   = rsp_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = iss_reg[IDX_W-1:0];

        // configuration transactions must arrive only while idle; the block does not enforce it
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:  frame_w_next = cfg.wdata;
                CFG_FRAME_HEIGHT: frame_h_next = cfg.wdata;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    transient_next = req.data.transient;
                    created_next   = PASS_BITS'(req.data.created_at);
                    last_use_next  = PASS_BITS'(req.data.last_used_at);
                    pin_next       = PASS_BITS'(pin_ext);
                    w_next   = (req.data.res_width == '0) ? frame_w_reg : req.data.res_width;
                    h_next   = (req.data.res_height == '0) ? frame_h_reg : req.data.res_height;
                    bpp_next = req.data.bytes_per_pixel;
                    if (req.data.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                wh_next    = WH_W'(w_reg) * WH_W'(h_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                size_next  = SIZE_W'(PROD_W'(wh_reg) * PROD_W'(bpp_reg));
                iss_next   = '0;
                found_next = 1'b0;
                state_next = transient_reg ? S_SCAN : S_DECIDE;
            end
            S_SCAN:
            begin
                // issue one read per cycle, compare each entry in the cycle after its read
                mem_re = (iss_reg < count_reg);
                if (mem_re)
                begin
                    iss_next      = iss_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = iss_reg[IDX_W-1:0];
                end
                if (pend_reg && ent_fits && (!found_reg || (best_bytes_reg > ent_bytes)))
                begin
                    found_next      = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_bytes_next = ent_bytes;
                end
                if (!mem_re && !pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (transient_reg && found_reg)
                begin
                    // reuse: block stays the same size, busy until last use
                    mem_we    = 1'b1;
                    mem_waddr = best_idx_reg;
                    mem_wdata = {best_bytes_reg, last_use_reg};
                    res_next  = '{block_index: BIDX_W'(best_idx_reg), reused: 1'b1,
                                  alias_recorded: 1'b1, table_full: 1'b0};
                end
                else if (table_is_full)
                begin
                    res_next = '{block_index: '0, reused: 1'b0,
                                 alias_recorded: 1'b0, table_full: 1'b1};
                end
                else
                begin
                    // open a new block at the end of the table
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IDX_W-1:0];
                    mem_wdata  = {size_reg, transient_reg ? last_use_reg : pin_reg};
                    count_next = count_reg + CNT_W'(1);
                    res_next   = '{block_index: BIDX_W'(count_reg), reused: 1'b0,
                                   alias_recorded: transient_reg, table_full: 1'b0};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            frame_w_reg   <= FRAME_WIDTH_RST;
            frame_h_reg   <= FRAME_HEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            frame_w_reg   <= frame_w_next;
            frame_h_reg   <= frame_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        transient_reg  <= transient_next;
        created_reg    <= created_next;
        last_use_reg   <= last_use_next;
        pin_reg        <= pin_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        bpp_reg        <= bpp_next;
        wh_reg         <= wh_next;
        size_reg       <= size_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_bytes_reg <= best_bytes_next;
        res_reg        <= res_next;
        rsp_data_reg   <= rsp_data_next;
    end

    // block count never passes the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    // the table is written only when an allocation is settled
    a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_DECIDE))
        else $error("table write outside decide step");

    // read data is only consumed during the scan
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN))
        else $error("table read pending outside scan");

    // a reused block is always a recorded alias and never a full table
    a_reuse_alias: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.reused)
            |-> (rsp_data_reg.alias_recorded && !rsp_data_reg.table_full))
        else $error("reuse without alias record");

    // opening a new block bumps the block count by one
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && !(transient_reg && found_reg) && !table_is_full)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("block not opened");
endmodule

@@ hdl/lab_ram.sv @@
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module lab_ram #(
    parameter int WIDTH = lab_pkg::SIZE_W,
    parameter int DEPTH = lab_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ tb/tb_alloc_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard class: block table predictor and result checker for the allocator
package tb_alloc_pkg;

    import lab_pkg::*;

    localparam int PASS_TOP = (1 << PASS_BITS_DEF) - 1;

    class alias_table_scoreboard;

        logic [DIM_W-1:0]         frame_w;
        logic [DIM_W-1:0]         frame_h;
        logic [SIZE_W-1:0]        blk_bytes [MAX_BLOCKS_DEF];
        logic [PASS_BITS_DEF-1:0] blk_free_after [MAX_BLOCKS_DEF];
        int unsigned              blk_used;
        lab_rsp_t                 grants_due [$];

        int unsigned n_checked;
        int unsigned n_reuse;
        int unsigned n_full;
        int unsigned n_clear;
        int unsigned n_faults;

        function new();
            frame_w   = FRAME_WIDTH_RST;
            frame_h   = FRAME_HEIGHT_RST;
            blk_used  = 0;
            n_checked = 0;
            n_reuse   = 0;
            n_full    = 0;
            n_clear   = 0;
            n_faults  = 0;
        endfunction

        // appends one expected grant at the tail of the queue
        function void queue_grant(lab_rsp_t g);
            grants_due = {grants_due, g};
        endfunction

        function void write_frame_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH)
                frame_w = val;
            else if (idx == CFG_FRAME_HEIGHT)
                frame_h = val;
        endfunction

        // predicts the grant for one accepted request transaction
        function void note_lifetime(lab_req_t r);
            logic [DIM_W-1:0]         w;
            logic [DIM_W-1:0]         h;
            logic [63:0]              prod;
            logic [SIZE_W-1:0]        need;
            logic [RCNT_W-1:0]        pin9;
            logic [PASS_BITS_DEF-1:0] busy_to;
            int                       best;
            lab_rsp_t                 g;
            g = '0;
            if (r.kind == KIND_CLEAR)
            begin
                blk_used = 0;
                n_clear++;
                queue_grant(g);
                return;
            end
            w    = (r.res_width == '0) ? frame_w : r.res_width;
            h    = (r.res_height == '0) ? frame_h : r.res_height;
            prod = 64'(w) * 64'(h) * 64'(r.bytes_per_pixel);
            need = prod[SIZE_W-1:0];
            best = -1;
            if (r.transient)
            begin
                // best fit, strict compare keeps the lowest index on ties
                for (int i = 0; i < int'(blk_used); i++)
                begin
                    if (blk_bytes[i] >= need && blk_free_after[i] < r.created_at)
                    begin
                        if (best < 0 || blk_bytes[best] > blk_bytes[i])
                            best = i;
                    end
                end
                if (best >= 0)
                begin
                    blk_free_after[best] = r.last_used_at;
                    g.block_index        = BIDX_W'(best);
                    g.reused             = 1'b1;
                    g.alias_recorded     = 1'b1;
                    n_reuse++;
                    queue_grant(g);
                    return;
                end
                busy_to = r.last_used_at;
            end
            else
            begin
                pin9    = r.resource_count - 1'b1;
                busy_to = (int'(pin9) > PASS_TOP) ? PASS_BITS_DEF'(PASS_TOP)
                                                  : pin9[PASS_BITS_DEF-1:0];
            end
            if (blk_used >= MAX_BLOCKS_DEF)
            begin
                g.table_full = 1'b1;
                n_full++;
                queue_grant(g);
                return;
            end
            blk_bytes[blk_used]      = need;
            blk_free_after[blk_used] = busy_to;
            g.block_index            = BIDX_W'(blk_used);
            g.alias_recorded         = r.transient;
            blk_used++;
            queue_grant(g);
        endfunction

        function void check_grant(lab_rsp_t got);
            lab_rsp_t want;
            if (grants_due.size() == 0)
            begin
                n_faults++;
                if (n_faults <= 10)
                    $display("unexpected grant: idx %0d reused %0b alias %0b full %0b",
                             got.block_index, got.reused, got.alias_recorded, got.table_full);
                return;
            end
            want = grants_due.pop_front();
            n_checked++;
            if (got.block_index !== want.block_index || got.reused !== want.reused ||
                got.alias_recorded !== want.alias_recorded ||
                got.table_full !== want.table_full)
            begin
                n_faults++;
                if (n_faults <= 10)
                begin
                    $display("grant %0d mismatch: exp idx %0d reused %0b alias %0b full %0b,",
                             n_checked, want.block_index, want.reused,
                             want.alias_recorded, want.table_full);
                    $display("    got idx %0d reused %0b alias %0b full %0b",
                             got.block_index, got.reused, got.alias_recorded,
                             got.table_full);
                end
            end
        endfunction

        function int unsigned grants_pending();
            return grants_due.size();
        endfunction

    endclass

endpackage

@@ tb/tb_lifetime_alias_block_allocator.sv @@
`timescale 1ns / 1ps
// testbench top: random lifetimes, frame size settings and stalls against a table predictor
module tb_lifetime_alias_block_allocator;

    import lab_pkg::*;
    import tb_alloc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lab_cfg_if cfg_ch ();
    lab_req_if req_ch ();
    lab_rsp_if rsp_ch ();

    lifetime_alias_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    alias_table_scoreboard sb;

    // calm flags switch idling off for a whole frame on either side
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;
    int unsigned hold_left = 0;
    int unsigned n_sent    = 0;
    int unsigned n_settings = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(99);
        if (calm)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result sink: random stalls unless the current frame runs calm
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!rx_calm && $urandom_range(99) < 20)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= pick_gap(1'b0);
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: register writes update the predictor, grants are checked,
    // accepted requests produce the next expectations
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_frame_reg(cfg_ch.index, cfg_ch.wdata);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_grant(rsp_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_lifetime(req_ch.data);
        end
    end

    // one request transaction; valid stays high when no gap follows
    task automatic send_request(input lab_req_t r, input int unsigned gap);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_sent++;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off requests until every grant is back, then let the block settle
    task automatic drain(input int unsigned settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.grants_pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // both frame size registers, back to back on the write channel
    task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_FRAME_WIDTH;
        cfg_ch.wdata <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_FRAME_HEIGHT;
        cfg_ch.wdata <= h;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        n_settings++;
        repeat (2) @(posedge clk);
    endtask

    function automatic lab_req_t life_req(input logic kind, input int unsigned c,
                                          input int unsigned l, input int unsigned w,
                                          input int unsigned h, input int unsigned bpp,
                                          input logic tr, input int unsigned cnt);
        lab_req_t r;
        r.kind            = kind;
        r.created_at      = POS_W'(c);
        r.last_used_at    = POS_W'(l);
        r.res_width       = DIM_W'(w);
        r.res_height      = DIM_W'(h);
        r.bytes_per_pixel = BPP_W'(bpp);
        r.transient       = tr;
        r.resource_count  = RCNT_W'(cnt);
        return r;
    endfunction

    // noise: every field bit uniformly random
    function automatic lab_req_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return lab_req_t'(raw[$bits(lab_req_t)-1:0]);
    endfunction

    // dimensions: zero (frame size), a small palette that makes reuse likely,
    // the extremes, or anything
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return '0;
        if (roll < 70)
            return DIM_W'(16 * $urandom_range(1, 8));
        if (roll < 80)
            return ($urandom_range(1) != 0) ? DIM_W'(1) : DIM_W'(16383);
        return DIM_W'($urandom_range(0, 16383));
    endfunction

    function automatic logic [BPP_W-1:0] pick_bpp();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return BPP_W'(1 << $urandom_range(0, 4));
        if (roll < 90)
            return BPP_W'($urandom_range(1, 16));
        return BPP_W'($urandom_range(0, 31));
    endfunction

    // one frame: a clear, then lifetimes sorted by creation pass; a fill frame
    // is mostly pinned resources so that the table overflows
    task automatic run_frame(input int unsigned n_life, input bit fill);
        lab_req_t    r;
        int unsigned pos;
        int unsigned stop;
        int unsigned roll;
        tx_calm = ($urandom_range(99) < 20);
        rx_calm = ($urandom_range(99) < 20);
        r = random_item();
        r.kind = KIND_CLEAR;
        send_request(r, pick_gap(tx_calm));
        pos = $urandom_range(0, 8);
        for (int unsigned k = 0; k < n_life; k++)
        begin
            if ($urandom_range(99) < 7)
            begin
                r = random_item();
            end
            else
            begin
                roll = $urandom_range(99);
                stop = (roll < 80) ? pos + $urandom_range(0, 12) : pos + $urandom_range(0, 255);
                if (stop > 255)
                    stop = 255;
                if (roll >= 95)
                    stop = $urandom_range(0, 255);
                r.kind            = KIND_ALLOC;
                r.created_at      = POS_W'(pos);
                r.last_used_at    = POS_W'(stop);
                r.res_width       = pick_dim();
                r.res_height      = pick_dim();
                r.bytes_per_pixel = pick_bpp();
                r.transient       = fill ? ($urandom_range(99) < 10) : ($urandom_range(99) < 75);
                roll = $urandom_range(99);
                if (roll < 80)
                    r.resource_count = RCNT_W'(n_life + $urandom_range(0, 20));
                else if (roll < 90)
                    r.resource_count = RCNT_W'($urandom_range(0, 511));
                else
                    r.resource_count = ($urandom_range(1) != 0) ? RCNT_W'(1) : RCNT_W'(256);
            end
            send_request(r, pick_gap(tx_calm));
            pos = pos + $urandom_range(0, 3);
            if (pos > 255)
                pos = 255;
        end
    endtask

    // hand-picked opening: extremes, pins, reuse, ties, zero size, clears
    task automatic run_directed();
        send_request(life_req(KIND_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0), 0);
        // pin at count 256 -> last pass
        send_request(life_req(KIND_ALLOC, 0, 0, 0, 0, 4, 1'b0, 256), pick_gap(1'b0));
        // largest size, nothing free before pass zero
        send_request(life_req(KIND_ALLOC, 0, 3, 16383, 16383, 31, 1'b1, 1), 0);
        // tiny resources reuse the big block once it frees up
        send_request(life_req(KIND_ALLOC, 5, 9, 1, 1, 1, 1'b1, 20), pick_gap(1'b0));
        send_request(life_req(KIND_ALLOC, 10, 10, 1, 1, 1, 1'b1, 20), 0);
        // count zero wraps and saturates, count one pins at pass zero
        send_request(life_req(KIND_ALLOC, 10, 10, 100, 100, 16, 1'b0, 0), 0);
        send_request(life_req(KIND_ALLOC, 10, 10, 100, 100, 16, 1'b0, 1), pick_gap(1'b0));
        send_request(life_req(KIND_ALLOC, 1, 2, 100, 100, 16, 1'b1, 20), 0);
        // zero bytes per pixel, best fit among several free blocks
        send_request(life_req(KIND_ALLOC, 255, 255, 5, 5, 0, 1'b1, 20), 0);
        send_request(life_req(KIND_ALLOC, 255, 255, 16383, 16383, 31, 1'b1, 20), 0);
        // last use before creation, no block free
        send_request(life_req(KIND_ALLOC, 255, 0, 16383, 16383, 31, 1'b1, 20), pick_gap(1'b0));
        // clear with every other field at its top
        send_request(life_req(KIND_CLEAR, 255, 255, 16383, 16383, 31, 1'b1, 511), 0);
        // equal sizes: ties go to the lowest index
        send_request(life_req(KIND_ALLOC, 0, 0, 8, 8, 2, 1'b1, 511), 0);
        send_request(life_req(KIND_ALLOC, 0, 0, 8, 8, 2, 1'b1, 511), 0);
        send_request(life_req(KIND_ALLOC, 1, 1, 8, 8, 2, 1'b1, 511), 0);
        send_request(life_req(KIND_ALLOC, 2, 4, 8, 8, 1, 1'b1, 511), pick_gap(1'b0));
        // pin beyond the pass range saturates
        send_request(life_req(KIND_ALLOC, 2, 2, 0, 16383, 16, 1'b0, 300), 0);
        send_request(life_req(KIND_ALLOC, 255, 255, 16383, 16383, 31, 1'b0, 511), 0);
        send_request(life_req(KIND_ALLOC, 255, 255, 16383, 0, 31, 1'b1, 511), pick_gap(1'b0));
    endtask

    initial
    begin
        logic [DIM_W-1:0] set_w [6];
        logic [DIM_W-1:0] set_h [6];
        int unsigned      phase_start;
        int unsigned      fr;
        sb = new();
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_FRAME_WIDTH;
        cfg_ch.wdata = '0;

        // frame size settings per phase; phase zero keeps the reset values
        set_w[0] = FRAME_WIDTH_RST;
        set_h[0] = FRAME_HEIGHT_RST;
        set_w[1] = 14'd16383;
        set_h[1] = 14'd16383;
        set_w[2] = 14'd1;
        set_h[2] = 14'd1;
        set_w[3] = 14'd0;
        set_h[3] = 14'd16383;
        set_w[4] = DIM_W'($urandom_range(1, 2048));
        set_h[4] = DIM_W'($urandom_range(1, 2048));
        set_w[5] = DIM_W'($urandom_range(1, 16383));
        set_h[5] = DIM_W'($urandom_range(0, 16383));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 0)
            begin
                run_directed();
            end
            else
            begin
                // registers change only while the block is idle
                drain(4);
                set_frame_size(set_w[ph], set_h[ph]);
            end
            phase_start = n_sent;
            fr = 0;
            while (n_sent - phase_start < 210)
            begin
                if (fr == 1)
                    run_frame($urandom_range(68, 80), 1'b1);
                else if ($urandom_range(99) < 70)
                    run_frame($urandom_range(4, 24), 1'b0);
                else
                    run_frame($urandom_range(25, 50), 1'b0);
                // sender waits for the block to empty once per phase
                if (fr == 3)
                    drain(0);
                fr++;
            end
        end

        tx_calm = 1'b0;
        drain(80);

        $display("ran %0d requests over %0d frame size settings plus reset values",
                 n_sent, n_settings);
        $display("checked %0d grants: %0d reuses, %0d table overflows, %0d clears",
                 sb.n_checked, sb.n_reuse, sb.n_full, sb.n_clear);
        if (sb.n_faults == 0 && sb.grants_pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d faults, %0d grants never seen", sb.n_faults, sb.grants_pending());
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
